FILE: rtl/huf_pkg.sv
// shared types, codes and constants of the huffman tree codec
package huf_pkg;

   localparam int MAX_SYMBOLS_DEF = 64;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int NODE_WEIGHT_W = 22;
   localparam logic [NODE_WEIGHT_W-1:0] WEIGHT_SAT = 22'h3FFFFF;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ADD    = 2'd0;
   localparam kind_type KIND_BUILD  = 2'd1;
   localparam kind_type KIND_DECODE = 2'd2;
   localparam kind_type KIND_ENCODE = 2'd3;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_LIST_FULL   = 3'd1;
   localparam status_type ST_NO_SYMBOLS  = 3'd2;
   localparam status_type ST_NO_TREE     = 3'd3;
   localparam status_type ST_ABSENT      = 3'd4;
   localparam status_type ST_BIT_INVALID = 3'd5;

   typedef logic [4:0] op_type;
   localparam op_type OP_NONE      = 5'd0;
   localparam op_type OP_LATCH     = 5'd1;
   localparam op_type OP_ADD       = 5'd2;
   localparam op_type OP_RES_ST    = 5'd3;
   localparam op_type OP_INS_RD    = 5'd4;
   localparam op_type OP_INS_SHIFT = 5'd5;
   localparam op_type OP_INS_PUT   = 5'd6;
   localparam op_type OP_MRG_RD    = 5'd7;
   localparam op_type OP_POPA      = 5'd8;
   localparam op_type OP_POPB      = 5'd9;
   localparam op_type OP_PARB      = 5'd10;
   localparam op_type OP_ROOT      = 5'd11;
   localparam op_type OP_DEC_RD    = 5'd12;
   localparam op_type OP_DEC1      = 5'd13;
   localparam op_type OP_DEC2      = 5'd14;
   localparam op_type OP_ENC_START = 5'd15;
   localparam op_type OP_VIS_DOWN  = 5'd16;
   localparam op_type OP_VIS_FOUND = 5'd17;
   localparam op_type OP_BT_RD     = 5'd18;
   localparam op_type OP_BTP       = 5'd19;
   localparam op_type OP_BTN_RIGHT = 5'd20;
   localparam op_type OP_BTN_UP    = 5'd21;
   localparam op_type OP_PUSH      = 5'd22;
   localparam op_type OP_PUSH_BIT  = 5'd23;

   typedef struct packed {
      op_type     op;
      status_type st;
      logic       last;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     pend_zero;
      logic     full;
      logic     pend_gt1;
      logic     tree_ready;
      logic     root_leaf;
      logic     scan_zero;
      logic     ins_shift;
      logic     leaf;
      logic     char_match;
      logic     depth_zero;
      logic     at_root;
      logic     is_left;
      logic     out_free;
      logic     emit_last;
   } flags_type;

endpackage

FILE: rtl/huf_req_if.sv
// request channel of the huffman tree codec
interface huf_req_if import huf_pkg::*; #(
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   kind_type               kind;
   logic [WEIGHT_BITS-1:0] weight;
   logic [7:0]             symbol;
   logic                   code_bit;

   modport source (output valid, kind, weight, symbol, code_bit, input ready);
   modport sink   (input valid, kind, weight, symbol, code_bit, output ready);
endinterface

FILE: rtl/huf_rsp_if.sv
// response channel of the huffman tree codec
interface huf_rsp_if import huf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic                     has_symbol;
   logic [7:0]               decoded_symbol;
   logic                     out_bit;
   logic [NODE_WEIGHT_W-1:0] root_weight;
   logic                     last;

   modport source (output valid, status, has_symbol, decoded_symbol, out_bit,
                   root_weight, last, input ready);
   modport sink   (input valid, status, has_symbol, decoded_symbol, out_bit,
                   root_weight, last, output ready);
endinterface

FILE: rtl/huffman_tree_codec.sv
// top level of the huffman tree codec: sequencer plus table datapath
// add: write the leaf, shift heavier list entries up, then put the new entry in place
// build: per merge pop the two lightest, write the parent node and links, insert it
// decode reads the node, then its child; encode descends left, backtracks by parents,
// then emits its code bits; one item at a time, next taken while a response waits
// reset is synchronous: counts and tree flag clear, node and list rams need none
module huffman_tree_codec import huf_pkg::*; #(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   huf_req_if.sink    req_ch,
   huf_rsp_if.source  rsp_ch
);
   // command and status between sequencer and datapath
   cmd_type   cmd;
   flags_type fl;

   // sequencer owns the request handshake
   huf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .fl        (fl),
      .cmd       (cmd)
   );

   // datapath holds the tables and the response register
   huf_dpath #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .fl                 (fl),
      .req_kind           (req_ch.kind),
      .req_weight         (req_ch.weight),
      .req_symbol         (req_ch.symbol),
      .req_code_bit       (req_ch.code_bit),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_status         (rsp_ch.status),
      .rsp_has_symbol     (rsp_ch.has_symbol),
      .rsp_decoded_symbol (rsp_ch.decoded_symbol),
      .rsp_out_bit        (rsp_ch.out_bit),
      .rsp_root_weight    (rsp_ch.root_weight),
      .rsp_last           (rsp_ch.last)
   );
endmodule

FILE: rtl/huf_ram.sv
// generic single write port ram with registered read
module huf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/huf_ctrl.sv
// sequencer of the huffman tree codec
module huf_ctrl import huf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  flags_type fl,
   output cmd_type   cmd
);
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_INS_RD = 5'd2;
   localparam logic [4:0] S_INS_CK = 5'd3;
   localparam logic [4:0] S_MRG    = 5'd4;
   localparam logic [4:0] S_MRG2   = 5'd5;
   localparam logic [4:0] S_POPB   = 5'd6;
   localparam logic [4:0] S_PARB   = 5'd7;
   localparam logic [4:0] S_DEC1   = 5'd8;
   localparam logic [4:0] S_DEC2   = 5'd9;
   localparam logic [4:0] S_VIS    = 5'd10;
   localparam logic [4:0] S_BT     = 5'd11;
   localparam logic [4:0] S_BTP    = 5'd12;
   localparam logic [4:0] S_BTN    = 5'd13;
   localparam logic [4:0] S_EMIT   = 5'd14;
   localparam logic [4:0] S_BITS   = 5'd15;

   logic [4:0] state_ff, state_in;
   logic [4:0] ins_done;

   assign req_ready = (state_ff == S_IDLE);
   // after the list insert an add reports, a build merges on
   assign ins_done = (fl.kind == KIND_ADD) ? S_EMIT : S_MRG;

   always_comb begin
      state_in = state_ff;
      cmd      = '{op: OP_NONE, st: ST_OK, last: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (fl.kind)
               KIND_ADD: begin
                  if (fl.full) begin
                     cmd.op = OP_RES_ST; cmd.st = ST_LIST_FULL; state_in = S_EMIT;
                  end else begin
                     cmd.op = OP_ADD; state_in = S_INS_RD;
                  end
               end
               KIND_BUILD: begin
                  if (fl.pend_zero) begin
                     cmd.op = OP_RES_ST; cmd.st = ST_NO_SYMBOLS; state_in = S_EMIT;
                  end else begin
                     state_in = S_MRG;
                  end
               end
               KIND_DECODE: begin
                  if (!fl.tree_ready) begin
                     cmd.op = OP_RES_ST; cmd.st = ST_NO_TREE; state_in = S_EMIT;
                  end else if (fl.root_leaf) begin
                     cmd.op = OP_RES_ST; cmd.st = ST_BIT_INVALID; state_in = S_EMIT;
                  end else begin
                     cmd.op = OP_DEC_RD; state_in = S_DEC1;
                  end
               end
               default: begin
                  if (!fl.tree_ready) begin
                     cmd.op = OP_RES_ST; cmd.st = ST_NO_TREE; cmd.last = 1'b1;
                     state_in = S_EMIT;
                  end else begin
                     cmd.op = OP_ENC_START; state_in = S_VIS;
                  end
               end
            endcase
         end
         S_INS_RD: begin
            if (fl.scan_zero) begin
               cmd.op = OP_INS_PUT; state_in = ins_done;
            end else begin
               cmd.op = OP_INS_RD; state_in = S_INS_CK;
            end
         end
         S_INS_CK: begin
            if (fl.ins_shift) begin
               cmd.op = OP_INS_SHIFT; state_in = S_INS_RD;
            end else begin
               cmd.op = OP_INS_PUT; state_in = ins_done;
            end
         end
         S_MRG: begin
            cmd.op = OP_MRG_RD; state_in = S_MRG2;
         end
         S_MRG2: begin
            if (fl.pend_gt1) begin
               cmd.op = OP_POPA; state_in = S_POPB;
            end else begin
               cmd.op = OP_ROOT; state_in = S_EMIT;
            end
         end
         S_POPB: begin
            cmd.op = OP_POPB; state_in = S_PARB;
         end
         S_PARB: begin
            cmd.op = OP_PARB; state_in = S_INS_RD;
         end
         S_DEC1: begin
            cmd.op = OP_DEC1; state_in = S_DEC2;
         end
         S_DEC2: begin
            cmd.op = OP_DEC2; state_in = S_EMIT;
         end
         S_VIS: begin
            if (fl.leaf && fl.char_match) begin
               if (fl.depth_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.op = OP_VIS_FOUND; state_in = S_BITS;
               end
            end else if (fl.leaf) begin
               state_in = S_BT;
            end else begin
               cmd.op = OP_VIS_DOWN; state_in = S_VIS;
            end
         end
         S_BT: begin
            if (fl.at_root) begin
               cmd.op = OP_RES_ST; cmd.st = ST_ABSENT; cmd.last = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.op = OP_BT_RD; state_in = S_BTP;
            end
         end
         S_BTP: begin
            cmd.op = OP_BTP; state_in = S_BTN;
         end
         S_BTN: begin
            if (fl.is_left) begin
               cmd.op = OP_BTN_RIGHT; state_in = S_VIS;
            end else begin
               cmd.op = OP_BTN_UP; state_in = S_BT;
            end
         end
         S_EMIT: begin
            if (fl.out_free) begin
               cmd.op = OP_PUSH; state_in = S_IDLE;
            end
         end
         S_BITS: begin
            if (fl.out_free) begin
               cmd.op = OP_PUSH_BIT;
               if (fl.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: rtl/huf_dpath.sv
// node table, ordered list, tree walk registers and response register
module huf_dpath import huf_pkg::*; #(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output flags_type                fl,
   input  kind_type                 req_kind,
   input  logic [WEIGHT_BITS-1:0]   req_weight,
   input  logic [7:0]               req_symbol,
   input  logic                     req_code_bit,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output status_type               rsp_status,
   output logic                     rsp_has_symbol,
   output logic [7:0]               rsp_decoded_symbol,
   output logic                     rsp_out_bit,
   output logic [NODE_WEIGHT_W-1:0] rsp_root_weight,
   output logic                     rsp_last
);
   localparam int NODE_DEPTH = 2 * MAX_SYMBOLS - 1;
   localparam int NA         = $clog2(NODE_DEPTH);
   localparam int CW         = $clog2(MAX_SYMBOLS + 1);
   localparam int DW         = $clog2(MAX_SYMBOLS);
   localparam int LA         = DW;
   localparam int LIST_DEPTH = 1 << LA;
   localparam int WW         = NODE_WEIGHT_W;
   localparam int NODE_W     = WW + 2 * NA + 9;
   localparam int LIST_W     = WW + NA;

   // node word: weight, left, right, char, leaf
   logic [NODE_W-1:0] n_rd, n_wd;
   logic [NA-1:0]     n_ra, n_wa;
   logic              n_we;
   logic [WW-1:0]     nd_w;
   logic [NA-1:0]     nd_left, nd_right;
   logic [7:0]        nd_char;
   logic              nd_leaf;

   // list word: weight, node index
   logic [LIST_W-1:0] l_rd, l_wd;
   logic [LA-1:0]     l_ra, l_wa;
   logic              l_we;
   logic [WW-1:0]     ld_w;
   logic [NA-1:0]     ld_idx;

   logic [NA-1:0]     p_rd, p_wd, p_ra, p_wa;
   logic              p_we;

   kind_type      kind_ff, kind_in;
   logic [WW-1:0] wt_ff, wt_in;
   logic [7:0]    sym_ff, sym_in;
   logic          bit_ff, bit_in;
   logic [CW-1:0] pend_ff, pend_in, scan_ff, scan_in;
   logic [NA-1:0] nc_ff, nc_in, root_ff, root_in, pos_ff, pos_in;
   logic          tree_ff, tree_in, root_leaf_ff, root_leaf_in, merged_ff, merged_in;
   logic [LA-1:0] head_ff, head_in;
   logic [NA-1:0] ins_idx_ff, ins_idx_in, a_idx_ff, a_idx_in, nxt_ff, nxt_in;
   logic [NA-1:0] cur_ff, cur_in, par_ff, par_in;
   logic [WW-1:0] ins_w_ff, ins_w_in, a_w_ff, a_w_in;
   logic [DW-1:0] depth_ff, depth_in, len_ff, len_in, ecnt_ff, ecnt_in;
   logic [MAX_SYMBOLS-1:0] path_ff, path_in;

   status_type    res_st_ff, res_st_in;
   logic          res_has_ff, res_has_in, res_last_ff, res_last_in;
   logic [7:0]    res_char_ff, res_char_in;
   logic [WW-1:0] res_rw_ff, res_rw_in;

   logic          o_valid_ff, o_valid_in, o_has_ff, o_has_in, o_bit_ff, o_bit_in;
   logic          o_last_ff, o_last_in;
   status_type    o_st_ff, o_st_in;
   logic [7:0]    o_char_ff, o_char_in;
   logic [WW-1:0] o_rw_ff, o_rw_in;

   logic [32:0]   w_wide;
   logic [WW:0]   sum;
   logic [WW-1:0] sum_sat;
   logic [NA-1:0] nc_eff, dec_next;
   logic          out_free;

   assign nd_w     = n_rd[NODE_W-1 -: WW];
   assign nd_left  = n_rd[2*NA+8 : NA+9];
   assign nd_right = n_rd[NA+8 : 9];
   assign nd_char  = n_rd[8:1];
   assign nd_leaf  = n_rd[0];
   assign ld_w     = l_rd[LIST_W-1 -: WW];
   assign ld_idx   = l_rd[NA-1:0];

   assign w_wide   = 33'(req_weight);
   assign sum      = {1'b0, a_w_ff} + {1'b0, ld_w};
   assign sum_sat  = sum[WW] ? WEIGHT_SAT : sum[WW-1:0];
   assign nc_eff   = (pend_ff == '0) ? '0 : nc_ff;
   assign dec_next = bit_ff ? nd_right : nd_left;
   assign out_free = !o_valid_ff || rsp_ready;

   huf_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(n_ra), .rd_data(n_rd)
   );
   huf_ram #(.WIDTH(LIST_W), .DEPTH(LIST_DEPTH)) u_list_ram (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(l_ra), .rd_data(l_rd)
   );
   huf_ram #(.WIDTH(NA), .DEPTH(NODE_DEPTH)) u_parent_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd)
   );

   always_comb begin
      fl.kind       = kind_ff;
      fl.pend_zero  = (pend_ff == '0);
      fl.full       = (pend_ff == CW'(MAX_SYMBOLS));
      fl.pend_gt1   = (pend_ff > CW'(1));
      fl.tree_ready = tree_ff;
      fl.root_leaf  = root_leaf_ff;
      fl.scan_zero  = (scan_ff == '0);
      fl.ins_shift  = (ld_w > ins_w_ff);
      fl.leaf       = nd_leaf;
      fl.char_match = (nd_char == sym_ff);
      fl.depth_zero = (depth_ff == '0);
      fl.at_root    = (cur_ff == root_ff);
      fl.is_left    = (cur_ff == nd_left);
      fl.out_free   = out_free;
      fl.emit_last  = (ecnt_ff == len_ff - DW'(1));
   end

   always_comb begin
      kind_in = kind_ff; wt_in = wt_ff; sym_in = sym_ff; bit_in = bit_ff;
      pend_in = pend_ff; scan_in = scan_ff; nc_in = nc_ff; root_in = root_ff;
      pos_in = pos_ff; tree_in = tree_ff; root_leaf_in = root_leaf_ff;
      merged_in = merged_ff; head_in = head_ff; ins_idx_in = ins_idx_ff;
      ins_w_in = ins_w_ff; a_idx_in = a_idx_ff; a_w_in = a_w_ff; nxt_in = nxt_ff;
      cur_in = cur_ff; par_in = par_ff; depth_in = depth_ff; len_in = len_ff;
      ecnt_in = ecnt_ff; path_in = path_ff;
      res_st_in = res_st_ff; res_has_in = res_has_ff; res_last_in = res_last_ff;
      res_char_in = res_char_ff; res_rw_in = res_rw_ff;
      o_st_in = o_st_ff; o_has_in = o_has_ff; o_char_in = o_char_ff;
      o_bit_in = o_bit_ff; o_rw_in = o_rw_ff; o_last_in = o_last_ff;
      o_valid_in = o_valid_ff && !rsp_ready;

      n_we = 1'b0; n_wa = nc_ff; n_wd = '0; n_ra = cur_ff;
      l_we = 1'b0; l_wa = LA'(head_ff + LA'(scan_ff)); l_wd = l_rd;
      l_ra = LA'(head_ff + LA'(scan_ff) - LA'(1));
      p_we = 1'b0; p_wa = a_idx_ff; p_wd = ins_idx_ff; p_ra = cur_ff;

      unique case (cmd.op)
         OP_LATCH: begin
            kind_in   = req_kind;
            wt_in     = (w_wide > 33'(WEIGHT_SAT)) ? WEIGHT_SAT : w_wide[WW-1:0];
            sym_in    = req_symbol;
            bit_in    = req_code_bit;
            merged_in = 1'b0;
         end
         OP_ADD: begin
            n_we       = 1'b1;
            n_wa       = nc_eff;
            n_wd       = {wt_ff, NA'(0), NA'(0), sym_ff, 1'b1};
            ins_idx_in = nc_eff;
            ins_w_in   = wt_ff;
            nc_in      = nc_eff + NA'(1);
            scan_in    = pend_ff;
            if (pend_ff == '0) begin
               tree_in = 1'b0; root_in = '0; pos_in = '0; head_in = '0;
            end
         end
         OP_RES_ST: begin
            res_st_in = cmd.st; res_last_in = cmd.last; res_has_in = 1'b0;
            res_char_in = '0; res_rw_in = '0;
         end
         OP_INS_RD: begin
         end
         OP_INS_SHIFT: begin
            l_we    = 1'b1;
            scan_in = scan_ff - CW'(1);
         end
         OP_INS_PUT: begin
            l_we    = 1'b1;
            l_wd    = {ins_w_ff, ins_idx_ff};
            pend_in = pend_ff + CW'(1);
            res_st_in = ST_OK; res_last_in = 1'b0; res_has_in = 1'b0;
            res_char_in = '0; res_rw_in = '0;
         end
         OP_MRG_RD: begin
            l_ra = head_ff;
         end
         OP_POPA: begin
            a_idx_in = ld_idx;
            a_w_in   = ld_w;
            l_ra     = head_ff + LA'(1);
         end
         OP_POPB: begin
            n_we       = 1'b1;
            n_wd       = {sum_sat, a_idx_ff, ld_idx, 8'd0, 1'b0};
            p_we       = 1'b1;
            p_wd       = nc_ff;
            ins_idx_in = nc_ff;
            ins_w_in   = sum_sat;
            a_idx_in   = ld_idx;
            head_in    = head_ff + LA'(2);
            pend_in    = pend_ff - CW'(2);
            scan_in    = pend_ff - CW'(2);
            nc_in      = nc_ff + NA'(1);
            merged_in  = 1'b1;
         end
         OP_PARB: begin
            p_we = 1'b1;
         end
         OP_ROOT: begin
            root_in      = ld_idx;
            pos_in       = ld_idx;
            root_leaf_in = !merged_ff;
            pend_in      = '0;
            tree_in      = 1'b1;
            res_st_in = ST_OK; res_last_in = 1'b0; res_has_in = 1'b0;
            res_char_in = '0; res_rw_in = ld_w;
         end
         OP_DEC_RD: begin
            n_ra = pos_ff;
         end
         OP_DEC1: begin
            nxt_in = dec_next;
            n_ra   = dec_next;
         end
         OP_DEC2: begin
            res_st_in = ST_OK; res_last_in = 1'b0; res_rw_in = '0;
            res_has_in  = nd_leaf;
            res_char_in = nd_leaf ? nd_char : 8'd0;
            pos_in      = nd_leaf ? root_ff : nxt_ff;
         end
         OP_ENC_START: begin
            cur_in   = root_ff;
            depth_in = '0;
            n_ra     = root_ff;
         end
         OP_VIS_DOWN: begin
            path_in[depth_ff] = 1'b0;
            depth_in = depth_ff + DW'(1);
            cur_in   = nd_left;
            n_ra     = nd_left;
         end
         OP_VIS_FOUND: begin
            len_in  = depth_ff;
            ecnt_in = '0;
         end
         OP_BT_RD: begin
         end
         OP_BTP: begin
            par_in = p_rd;
            n_ra   = p_rd;
         end
         OP_BTN_RIGHT: begin
            path_in[depth_ff - DW'(1)] = 1'b1;
            cur_in = nd_right;
            n_ra   = nd_right;
         end
         OP_BTN_UP: begin
            cur_in   = par_ff;
            depth_in = depth_ff - DW'(1);
         end
         OP_PUSH: begin
            o_valid_in = 1'b1;
            o_st_in = res_st_ff; o_has_in = res_has_ff; o_char_in = res_char_ff;
            o_bit_in = 1'b0; o_rw_in = res_rw_ff; o_last_in = res_last_ff;
         end
         OP_PUSH_BIT: begin
            o_valid_in = 1'b1;
            o_st_in = ST_OK; o_has_in = 1'b0; o_char_in = '0;
            o_bit_in = path_ff[ecnt_ff]; o_rw_in = '0;
            o_last_in = (ecnt_ff == len_ff - DW'(1));
            ecnt_in = ecnt_ff + DW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         nc_ff        <= '0;
         root_ff      <= '0;
         pos_ff       <= '0;
         tree_ff      <= 1'b0;
         root_leaf_ff <= 1'b0;
         head_ff      <= '0;
         o_valid_ff   <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         nc_ff        <= nc_in;
         root_ff      <= root_in;
         pos_ff       <= pos_in;
         tree_ff      <= tree_in;
         root_leaf_ff <= root_leaf_in;
         head_ff      <= head_in;
         o_valid_ff   <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; wt_ff <= wt_in; sym_ff <= sym_in; bit_ff <= bit_in;
      scan_ff <= scan_in; merged_ff <= merged_in; ins_idx_ff <= ins_idx_in;
      ins_w_ff <= ins_w_in; a_idx_ff <= a_idx_in; a_w_ff <= a_w_in; nxt_ff <= nxt_in;
      cur_ff <= cur_in; par_ff <= par_in; depth_ff <= depth_in; len_ff <= len_in;
      ecnt_ff <= ecnt_in; path_ff <= path_in;
      res_st_ff <= res_st_in; res_has_ff <= res_has_in; res_last_ff <= res_last_in;
      res_char_ff <= res_char_in; res_rw_ff <= res_rw_in;
      o_st_ff <= o_st_in; o_has_ff <= o_has_in; o_char_ff <= o_char_in;
      o_bit_ff <= o_bit_in; o_rw_ff <= o_rw_in; o_last_ff <= o_last_in;
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_status         = o_st_ff;
   assign rsp_has_symbol     = o_has_ff;
   assign rsp_decoded_symbol = o_char_ff;
   assign rsp_out_bit        = o_bit_ff;
   assign rsp_root_weight    = o_rw_ff;
   assign rsp_last           = o_last_ff;
endmodule

FILE: rtl/huf_checker.sv
// port level checks of the huffman tree codec and their bind
module huf_checker import huf_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input status_type               rsp_status,
   input logic                     rsp_has_symbol,
   input logic [7:0]               rsp_decoded_symbol,
   input logic                     rsp_out_bit,
   input logic [NODE_WEIGHT_W-1:0] rsp_root_weight,
   input logic                     rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_bit) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_sym_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_symbol |-> rsp_status == ST_OK && !rsp_last
         && !rsp_out_bit && rsp_root_weight == '0)
      else $error("decoded symbol on a non decode response");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_has_symbol && !rsp_out_bit
         && rsp_decoded_symbol == 8'd0 && rsp_root_weight == '0)
      else $error("error response carries data");

   a_root_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_weight != '0 |-> !rsp_last && !rsp_has_symbol)
      else $error("root weight on a non build response");
endmodule

bind huffman_tree_codec huf_checker u_huf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_has_symbol     (rsp_ch.has_symbol),
   .rsp_decoded_symbol (rsp_ch.decoded_symbol),
   .rsp_out_bit        (rsp_ch.out_bit),
   .rsp_root_weight    (rsp_ch.root_weight),
   .rsp_last           (rsp_ch.last)
);

FILE: bench/tb_huffman_tree_codec.sv
// self-checking bench for the huffman tree codec: random and directed items
module tb_huffman_tree_codec;
   import huf_pkg::*;

   localparam int NSYM  = MAX_SYMBOLS_DEF;
   localparam int NDEP  = 2 * NSYM - 1;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct packed {
      status_type            status;
      logic                  has_symbol;
      logic [7:0]            decoded_symbol;
      logic                  out_bit;
      logic [NODE_WEIGHT_W-1:0] root_weight;
      logic                  last;
   } codec_rsp_t;

   // scoreboard: a software copy of the tree and list, plus pending responses
   class codec_scoreboard;
      logic [NODE_WEIGHT_W-1:0] wt [NDEP];
      int                       lchild [NDEP];
      int                       rchild [NDEP];
      logic [7:0]               ch [NDEP];
      bit                       leaf [NDEP];
      int                       order_q [$];
      int                       n_nodes, root, pos;
      bit                       have_tree;
      codec_rsp_t               pending_q [$];
      int                       n_errors, n_checked, n_symbols;
      bit                       path [$];

      function void clear();
         order_q.delete();
         n_nodes = 0; root = 0; pos = 0; have_tree = 0;
      endfunction

      function void insert_sorted(int idx);
         int p;
         p = 0;
         if (order_q.size() >= NSYM) return;
         while (p < order_q.size() && wt[order_q[p]] <= wt[idx]) p++;
         order_q.insert(p, idx);
      endfunction

      function bit find_path(int n, logic [7:0] sym, int depth);
         if (n >= NDEP || depth >= NSYM) return 0;
         if (leaf[n]) return ch[n] == sym;
         path.push_back(1'b0);
         if (find_path(lchild[n], sym, depth + 1)) return 1;
         path[path.size() - 1] = 1'b1;
         if (find_path(rchild[n], sym, depth + 1)) return 1;
         void'(path.pop_back());
         return 0;
      endfunction

      function void push(status_type st, bit has, logic [7:0] sym, bit b,
                         logic [NODE_WEIGHT_W-1:0] rw, bit lst);
         codec_rsp_t r;
         r = '{st, has, sym, b, rw, lst};
         pending_q.push_back(r);
      endfunction

      // predicts the responses of one accepted request
      function void note_request(kind_type k, logic [15:0] w, logic [7:0] sym, bit cb);
         int a, b, nxt;
         logic [22:0] s;
         case (k)
            KIND_ADD: begin
               if (order_q.size() == 0) clear();
               if (order_q.size() >= NSYM || n_nodes >= NDEP) begin
                  push(ST_LIST_FULL, 0, 0, 0, 0, 0);
               end else begin
                  wt[n_nodes] = NODE_WEIGHT_W'(w); ch[n_nodes] = sym; leaf[n_nodes] = 1;
                  lchild[n_nodes] = 0; rchild[n_nodes] = 0;
                  insert_sorted(n_nodes);
                  n_nodes++;
                  push(ST_OK, 0, 0, 0, 0, 0);
               end
            end
            KIND_BUILD: begin
               if (order_q.size() == 0) begin
                  push(ST_NO_SYMBOLS, 0, 0, 0, 0, 0);
               end else begin
                  while (order_q.size() > 1 && n_nodes < NDEP) begin
                     a = order_q.pop_front();
                     b = order_q.pop_front();
                     s = {1'b0, wt[a]} + {1'b0, wt[b]};
                     wt[n_nodes] = (s > WEIGHT_SAT) ? WEIGHT_SAT : s[21:0];
                     lchild[n_nodes] = a; rchild[n_nodes] = b;
                     ch[n_nodes] = 0; leaf[n_nodes] = 0;
                     insert_sorted(n_nodes);
                     n_nodes++;
                  end
                  root = order_q[0];
                  order_q.delete();
                  have_tree = 1; pos = root;
                  push(ST_OK, 0, 0, 0, wt[root], 0);
               end
            end
            default: begin
               if (!have_tree) begin
                  push(ST_NO_TREE, 0, 0, 0, 0, k == KIND_ENCODE);
               end else if (k == KIND_DECODE) begin
                  if (leaf[root] || leaf[pos]) begin
                     push(ST_BIT_INVALID, 0, 0, 0, 0, 0);
                  end else begin
                     nxt = cb ? rchild[pos] : lchild[pos];
                     if (leaf[nxt]) begin
                        push(ST_OK, 1, ch[nxt], 0, 0, 0);
                        pos = root;
                     end else begin
                        push(ST_OK, 0, 0, 0, 0, 0);
                        pos = nxt;
                     end
                  end
               end else begin
                  path.delete();
                  if (!find_path(root, sym, 0)) begin
                     push(ST_ABSENT, 0, 0, 0, 0, 1);
                  end else begin
                     foreach (path[i]) push(ST_OK, 0, 0, path[i], 0, i == path.size() - 1);
                  end
               end
            end
         endcase
      endfunction

      function void check_response(codec_rsp_t act);
         codec_rsp_t exp_r;
         n_checked++;
         if (act.has_symbol) n_symbols++;
         if (pending_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected response %p", $time, act);
            return;
         end
         exp_r = pending_q.pop_front();
         if (act.status !== exp_r.status || act.has_symbol !== exp_r.has_symbol ||
             act.decoded_symbol !== exp_r.decoded_symbol ||
             act.out_bit !== exp_r.out_bit || act.root_weight !== exp_r.root_weight ||
             act.last !== exp_r.last) begin
            n_errors++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, act);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   huf_req_if req_ch ();
   huf_rsp_if rsp_ch ();

   huffman_tree_codec u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   codec_scoreboard sb = new();

   // request items laid out ahead of time, then streamed by the driver
   typedef struct packed {
      kind_type    kind;
      logic [15:0] weight;
      logic [7:0]  symbol;
      logic        code_bit;
   } codec_req_t;
   codec_req_t req_q [$];

   bit hold_off = 0;      // long receiver stall window
   bit sent_all = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   int n_req_sent = 0;

   // the symbols of the most recent collection, for encodes that hit
   logic [7:0] live_syms [$];

   function void add_req(kind_type k, logic [15:0] w, logic [7:0] s, bit b);
      req_q.push_back('{k, w, s, b});
   endfunction

   // a well-formed collection: n adds, a build, decodes and encodes
   function void add_session(int n, bit heavy);
      logic [7:0] s;
      live_syms.delete();
      for (int i = 0; i < n; i++) begin
         s = 8'($urandom_range(0, 255));
         live_syms.push_back(s);
         add_req(KIND_ADD, heavy ? 16'($urandom_range(60000, 65535)) :
                 16'($urandom_range(0, 65535) >> $urandom_range(0, 15)), s,
                 1'($urandom_range(0, 1)));
      end
      add_req(KIND_BUILD, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 6; i++)
         add_req(KIND_DECODE, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 3; i++)
         add_req(KIND_ENCODE, 16'($urandom),
                 ($urandom_range(0, 3) != 0) ? live_syms[$urandom_range(0, n - 1)]
                                             : 8'($urandom), 1'($urandom_range(0, 1)));
   endfunction

   function void plan_stimulus();
      // no tree yet: decode and encode are rejected, empty build too
      add_req(KIND_DECODE, 16'h0, 8'h00, 1'b1);
      add_req(KIND_ENCODE, 16'hFFFF, 8'hFF, 1'b0);
      add_req(KIND_BUILD, 16'h0, 8'h00, 1'b0);
      // single-leaf tree: decode bit invalid, encode of its symbol gives no response at all
      add_req(KIND_ADD, 16'hFFFF, 8'hA5, 1'b0);
      add_req(KIND_BUILD, 16'h0, 8'h00, 1'b0);
      add_req(KIND_DECODE, 16'h0, 8'h00, 1'b0);
      add_req(KIND_ENCODE, 16'h0, 8'hA5, 1'b0);
      add_req(KIND_ENCODE, 16'h0, 8'h5A, 1'b0);
      add_req(KIND_BUILD, 16'h0, 8'h00, 1'b0);   // empty build keeps the old tree
      add_req(KIND_ENCODE, 16'h0, 8'hA5, 1'b1);
      // equal weights, zero weight, extremes of symbol
      add_req(KIND_ADD, 16'h0000, 8'h00, 1'b1);
      add_req(KIND_ADD, 16'h0000, 8'hFF, 1'b0);
      add_req(KIND_ADD, 16'hFFFF, 8'h00, 1'b0);
      add_req(KIND_BUILD, 16'h0, 8'h00, 1'b0);
      add_req(KIND_DECODE, 16'h0, 8'h00, 1'b0);
      add_req(KIND_DECODE, 16'h0, 8'h00, 1'b1);
      add_req(KIND_DECODE, 16'h0, 8'h00, 1'b1);
      add_req(KIND_ENCODE, 16'h0, 8'h00, 1'b0);  // leftmost leaf with 0x00
      add_req(KIND_ENCODE, 16'h0, 8'hFF, 1'b0);
      // full list with heavy weights: the extra add is refused, then a deep tree
      live_syms.delete();
      for (int i = 0; i < NSYM; i++) begin
         live_syms.push_back(8'(i * 3));
         add_req(KIND_ADD, 16'($urandom_range(60000, 65535)), 8'(i * 3), 1'b0);
      end
      add_req(KIND_ADD, 16'h1, 8'h22, 1'b0);     // list full
      add_req(KIND_BUILD, 16'h0, 8'h00, 1'b0);
      for (int i = 0; i < 2; i++) add_req(KIND_DECODE, 16'h0, 8'h00, 1'(i));
      for (int i = 0; i < 2; i++)
         add_req(KIND_ENCODE, 16'h0, live_syms[$urandom_range(0, NSYM - 1)], 1'b0);
      // random tail: one small collection with light weights
      add_session($urandom_range(2, 4), 0);
   endfunction

   // sender: falling-edge drive, waits for the handshake at the rising edge
   task automatic send_item(codec_req_t it, bit no_gap);
      int gap;
      gap = $urandom_range(0, 6);
      if (no_gap) gap = 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= it.kind;
      req_ch.weight   <= it.weight;
      req_ch.symbol   <= it.symbol;
      req_ch.code_bit <= it.code_bit;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(it.kind, it.weight, it.symbol, it.code_bit);
      n_req_sent++;
      @(negedge clock);
   endtask

   initial begin
      req_ch.valid = 0; req_ch.kind = KIND_ADD; req_ch.weight = 0;
      req_ch.symbol = 0; req_ch.code_bit = 0;
      rsp_ch.ready = 0;
      plan_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // back-to-back stretch: no gap, valid held high between items
      foreach (req_q[i]) send_item(req_q[i], i >= 40 && i < 60);
      req_ch.valid <= 1'b0;
      sent_all = 1;
   end

   // receiver: random stall per item, a long hold-off early in the run
   initial begin
      int gap;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (n_req_sent >= 12 && !hold_off) begin
            hold_off = 1;
            rsp_ch.ready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (n_req_sent > 40 && n_req_sent < 60) gap = 0;
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // response monitor and watchdog on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response('{rsp_ch.status, rsp_ch.has_symbol, rsp_ch.decoded_symbol,
                                rsp_ch.out_bit, rsp_ch.root_weight, rsp_ch.last});
      end
   end

   initial begin
      wait (!reset);
      fork
         begin
            wait (sent_all && sb.pending_q.size() == 0);
            repeat (400) @(posedge clock);
            if (sb.pending_q.size() != 0) sb.n_errors++;
         end
         begin
            wait (idle_cycles >= WATCHDOG_LIMIT);
            timed_out = 1;
         end
      join_any
      if (timed_out) begin
         $display("watchdog expired at %0t", $time);
         $display("huffman_tree_codec verification failed");
         $finish;
      end else begin
         $display("sent %0d requests, checked %0d responses (%0d decoded symbols)",
                  n_req_sent, sb.n_checked, sb.n_symbols);
         $display("covered empty, single-leaf and full trees, list overflow and a long stall");
         if (sb.n_errors == 0)
            $display("huffman_tree_codec verification clean");
         else
            $display("huffman_tree_codec verification failed");
         $finish;
      end
   end

endmodule

FILE: huffman_tree_codec.f
rtl/huf_pkg.sv
rtl/huf_req_if.sv
rtl/huf_rsp_if.sv
rtl/huf_ram.sv
rtl/huf_ctrl.sv
rtl/huf_dpath.sv
rtl/huffman_tree_codec.sv
rtl/huf_checker.sv
bench/tb_huffman_tree_codec.sv
